// ----- hdl/scd_pkg.sv -----
// Shared types, codes and the scan code set 1 keymap for the scan code decoder.
// Depends on nothing; every other file in hdl uses it by scoped names.
package scd_pkg;

  // Scan code bytes with a special meaning.
  localparam logic [7:0] PREFIX_BYTE = 8'hE0;
  localparam logic [7:0] MAKE_UP     = 8'h48;
  localparam logic [7:0] MAKE_DOWN   = 8'h50;
  localparam logic [7:0] MAKE_LEFT   = 8'h4B;
  localparam logic [7:0] MAKE_RIGHT  = 8'h4D;

  // Key codes given to the arrow keys.
  localparam logic [7:0] ARROW_UP    = 8'h80;
  localparam logic [7:0] ARROW_DOWN  = 8'h81;
  localparam logic [7:0] ARROW_LEFT  = 8'h82;
  localparam logic [7:0] ARROW_RIGHT = 8'h83;

  // Input mode codes.
  localparam logic MODE_SCAN = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Depth of the result queue in the back end and its index width.
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = 2;

  // One classified request passed from the front end to the back end.
  typedef struct packed {
    logic       is_read;  // pop one key from the key FIFO
    logic       key_en;   // push key into the key FIFO
    logic [7:0] key;
  } op_t;

  // One result as it waits in the result queue.
  typedef struct packed {
    logic       key_valid;
    logic [7:0] key_code;
  } res_t;

  // US keymap for make codes 0x00 to 0x3F; a zero entry means no key.
  function automatic logic [7:0] us_map(input logic [5:0] idx);
    logic [7:0] k;
    case (idx)
      6'h01: k = 8'h1B;
      6'h02: k = 8'h31;
      6'h03: k = 8'h32;
      6'h04: k = 8'h33;
      6'h05: k = 8'h34;
      6'h06: k = 8'h35;
      6'h07: k = 8'h36;
      6'h08: k = 8'h37;
      6'h09: k = 8'h38;
      6'h0A: k = 8'h39;
      6'h0B: k = 8'h30;
      6'h0C: k = 8'h2D;
      6'h0D: k = 8'h3D;
      6'h0E: k = 8'h08;
      6'h0F: k = 8'h09;
      6'h10: k = 8'h71;
      6'h11: k = 8'h77;
      6'h12: k = 8'h65;
      6'h13: k = 8'h72;
      6'h14: k = 8'h74;
      6'h15: k = 8'h79;
      6'h16: k = 8'h75;
      6'h17: k = 8'h69;
      6'h18: k = 8'h6F;
      6'h19: k = 8'h70;
      6'h1A: k = 8'h5B;
      6'h1B: k = 8'h5D;
      6'h1C: k = 8'h0A;
      6'h1E: k = 8'h61;
      6'h1F: k = 8'h73;
      6'h20: k = 8'h64;
      6'h21: k = 8'h66;
      6'h22: k = 8'h67;
      6'h23: k = 8'h68;
      6'h24: k = 8'h6A;
      6'h25: k = 8'h6B;
      6'h26: k = 8'h6C;
      6'h27: k = 8'h3B;
      6'h28: k = 8'h27;
      6'h29: k = 8'h60;
      6'h2B: k = 8'h5C;
      6'h2C: k = 8'h7A;
      6'h2D: k = 8'h78;
      6'h2E: k = 8'h63;
      6'h2F: k = 8'h76;
      6'h30: k = 8'h62;
      6'h31: k = 8'h6E;
      6'h32: k = 8'h6D;
      6'h33: k = 8'h2C;
      6'h34: k = 8'h2E;
      6'h35: k = 8'h2F;
      6'h37: k = 8'h2A;
      6'h39: k = 8'h20;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

endpackage

// ----- hdl/scd_front.sv -----
// Front end of the scan code decoder: accepts requests, tracks the extended prefix
// and classifies each request into an op_t. Depends on scd_pkg.
module scd_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  logic           full,
  input  logic           mode,
  input  logic [7:0]     scan_byte,
  output logic           op_wr,
  output scd_pkg::op_t   op
);

  logic prefix_r;
  logic prefix_nxt;
  logic accept;

  assign accept = push & ~full;
  assign op_wr  = accept;

  always_comb begin
    prefix_nxt = prefix_r;
    op.is_read = 1'b0;
    op.key_en  = 1'b0;
    op.key     = 8'h00;
    if (mode == scd_pkg::MODE_READ) begin
      op.is_read = 1'b1;
    end else if (scan_byte == scd_pkg::PREFIX_BYTE) begin
      prefix_nxt = 1'b1;
    end else if (scan_byte[7]) begin
      // Break code: drop it and forget any pending prefix.
      prefix_nxt = 1'b0;
    end else if (prefix_r) begin
      prefix_nxt = 1'b0;
      op.key_en  = 1'b1;
      unique case (scan_byte)
        scd_pkg::MAKE_UP:    op.key = scd_pkg::ARROW_UP;
        scd_pkg::MAKE_DOWN:  op.key = scd_pkg::ARROW_DOWN;
        scd_pkg::MAKE_LEFT:  op.key = scd_pkg::ARROW_LEFT;
        scd_pkg::MAKE_RIGHT: op.key = scd_pkg::ARROW_RIGHT;
        default:             op.key_en = 1'b0;
      endcase
    end else if (!scan_byte[6]) begin
      op.key    = scd_pkg::us_map(scan_byte[5:0]);
      op.key_en = (op.key != 8'h00);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= 1'b0;
    end else if (accept) begin
      prefix_r <= prefix_nxt;
    end
  end

endmodule

// ----- hdl/scd_opq.sv -----
// Two-entry queue of classified requests between front end and back end.
// Depends on scd_pkg for op_t.
module scd_opq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr,
  input  scd_pkg::op_t   wr_op,
  output logic           full,
  input  logic           rd,
  output logic           empty,
  output scd_pkg::op_t   rd_op
);

  scd_pkg::op_t entry [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   cnt_r;
  logic         do_wr;
  logic         do_rd;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign do_wr = wr & ~full;
  assign do_rd = rd & ~empty;
  assign rd_op = entry[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry[wr_ptr_r] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_rd) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- hdl/scd_back.sv -----
// Back end of the scan code decoder: the key ring FIFO with its memory, and the
// result queue that faces the output. Depends on scd_pkg.
module scd_back #(
  parameter int FIFO_DEPTH = 128
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           op_empty,
  input  scd_pkg::op_t   op,
  output logic           op_rd,
  output logic           empty,
  input  logic           pop,
  output logic           key_valid,
  output logic [7:0]     key_code
);

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);

  logic [7:0]    key_mem [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW-1:0] wr_ptr_inc;
  logic [PW-1:0] rd_ptr_inc;
  logic          ring_empty;
  logic          ring_full;
  logic          issue;
  logic          do_push;
  logic          do_read;

  logic          s1_valid_r;
  logic          s1_hit_r;
  logic [7:0]    mem_q_r;

  scd_pkg::res_t              rq_mem [scd_pkg::RQ_DEPTH];
  logic [scd_pkg::RQ_AW-1:0]  rq_wr_r;
  logic [scd_pkg::RQ_AW-1:0]  rq_rd_r;
  logic [scd_pkg::RQ_AW:0]    rq_cnt_r;
  logic [scd_pkg::RQ_AW:0]    slots_used;
  logic                       rq_pop;
  scd_pkg::res_t              rq_in;
  scd_pkg::res_t              rq_out;

  assign wr_ptr_inc = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
  assign rd_ptr_inc = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
  assign ring_empty = (wr_ptr_r == rd_ptr_r);
  assign ring_full  = (wr_ptr_inc == rd_ptr_r);

  // An op is taken only when its result is sure to find room in the result queue,
  // counting the one that may still be in flight through the memory read.
  assign slots_used = rq_cnt_r + {{scd_pkg::RQ_AW{1'b0}}, s1_valid_r};
  assign issue      = ~op_empty & (slots_used < (scd_pkg::RQ_AW + 1)'(scd_pkg::RQ_DEPTH));
  assign op_rd      = issue;
  assign do_push    = issue & op.key_en & ~ring_full;
  assign do_read    = issue & op.is_read & ~ring_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      key_mem[wr_ptr_r] <= op.key;
    end
    if (do_read) begin
      mem_q_r <= key_mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      s1_valid_r <= 1'b0;
      s1_hit_r   <= 1'b0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_inc;
      end
      if (do_read) begin
        rd_ptr_r <= rd_ptr_inc;
      end
      s1_valid_r <= issue;
      s1_hit_r   <= do_read;
    end
  end

  assign rq_in.key_valid = s1_hit_r;
  assign rq_in.key_code  = s1_hit_r ? mem_q_r : 8'h00;
  assign rq_out          = rq_mem[rq_rd_r];
  assign empty           = (rq_cnt_r == '0);
  assign rq_pop          = pop & ~empty;
  assign key_valid       = rq_out.key_valid;
  assign key_code        = rq_out.key_code;

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      rq_mem[rq_wr_r] <= rq_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_r  <= '0;
      rq_rd_r  <= '0;
      rq_cnt_r <= '0;
    end else begin
      if (s1_valid_r) begin
        rq_wr_r <= rq_wr_r + scd_pkg::RQ_AW'(1);
      end
      if (rq_pop) begin
        rq_rd_r <= rq_rd_r + scd_pkg::RQ_AW'(1);
      end
      case ({s1_valid_r, rq_pop})
        2'b10:   rq_cnt_r <= rq_cnt_r + (scd_pkg::RQ_AW + 1)'(1);
        2'b01:   rq_cnt_r <= rq_cnt_r - (scd_pkg::RQ_AW + 1)'(1);
        default: rq_cnt_r <= rq_cnt_r;
      endcase
    end
  end

endmodule

// ----- hdl/scancode_to_key_fifo_top.sv -----
// Top level of the scan code set 1 decoder with key FIFO.
// Depends on scd_pkg, scd_front, scd_opq and scd_back.
//
//   channel   direction  handshake      payload
//   in_*      input      push / full    in_mode, in_scan_byte
//   out_*     output     empty / pop    out_key_valid, out_key_code
//
// Every request yields exactly one result, in request order. A scan byte gives a
// result with valid low and code zero; a read gives the oldest queued key, or
// valid low and code zero when no key is queued.
//
// One request per cycle is sustained while pop is held high. Requests pass the
// request queue, the registered key memory read and the result queue in turn.
// Reset is synchronous and active low; it empties every queue and clears the
// extended prefix but leaves the key memory, which is never read before written.
// With pop held low the result queue fills, the back end stops taking requests,
// the two-entry request queue fills and full rises.
module scancode_to_key_fifo_top #(
  parameter int FIFO_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic       in_mode,
  input  logic [7:0] in_scan_byte,
  output logic       empty,
  input  logic       pop,
  output logic       out_key_valid,
  output logic [7:0] out_key_code
);

  // Classified request from the front end and its queue handshake.
  logic         op_wr;
  scd_pkg::op_t front_op;
  logic         op_rd;
  logic         op_empty;
  scd_pkg::op_t back_op;

  // The front end tracks the extended prefix and turns each request into an op.
  scd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .mode      (in_mode),
    .scan_byte (in_scan_byte),
    .op_wr     (op_wr),
    .op        (front_op)
  );

  // The request queue lets the front keep accepting while the back end waits.
  scd_opq u_opq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (op_wr),
    .wr_op (front_op),
    .full  (full),
    .rd    (op_rd),
    .empty (op_empty),
    .rd_op (back_op)
  );

  // The back end owns the key ring and the result queue seen at the outputs.
  scd_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_empty  (op_empty),
    .op        (back_op),
    .op_rd     (op_rd),
    .empty     (empty),
    .pop       (pop),
    .key_valid (out_key_valid),
    .key_code  (out_key_code)
  );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the scan code set 1 decoder with its key FIFO.
// Depends on scd_pkg and scancode_to_key_fifo_top; it needs no other file.
// A built-in predictor keeps the key queue and the extended-prefix flag and checks every result.
module tb;

  localparam int FIFO_DEPTH = 128;

  // Bit 7 marks a key release in scan code set 1.
  localparam logic [7:0] RELEASE_MASK = 8'h80;

  // Make codes from 0x00 up to 0x39 have a keymap entry. Every code above that is unmapped.
  localparam int MAP_ENTRIES = 58;

  // The US keymap is packed into one vector, with entry 0 in the top byte.
  // A zero entry means that the make code produces no key.
  localparam logic [8*MAP_ENTRIES-1:0] KEYMAP = {
    8'h00, 8'h1B, "1234567890-=", 8'h08, 8'h09,
    "qwertyuiop[]", 8'h0A, 8'h00,
    "asdfghjkl;'", 8'h60, 8'h00,
    8'h5C, "zxcvbnm,./", 8'h00,
    "*", 8'h00, " "
  };

  typedef struct packed {
    logic       key_valid;
    logic [7:0] key_code;
  } key_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic       in_mode = scd_pkg::MODE_SCAN;
  logic [7:0] in_scan_byte = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic       out_key_valid;
  logic [7:0] out_key_code;

  // This is the predictor state. It holds the keys that the block should have queued and the prefix flag.
  logic [7:0]  queued_keys[$];
  logic        prefix_armed = 1'b0;
  key_result_t pending_results[$];

  int  mismatch_count = 0;
  int  requests_sent = 0;
  // While this flag is set, neither side idles.
  bit  steady_flow = 1'b0;

  scancode_to_key_fifo_top #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_mode      (in_mode),
    .in_scan_byte (in_scan_byte),
    .empty        (empty),
    .pop          (pop),
    .out_key_valid(out_key_valid),
    .out_key_code (out_key_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The ring keeps one slot free, so at most FIFO_DEPTH - 1 keys are held.
  // Any further key is dropped without notice.
  function automatic void store_key(input logic [7:0] key);
    if (queued_keys.size() < FIFO_DEPTH - 1) begin
      queued_keys.push_back(key);
    end
  endfunction

  function automatic void decode_scan_byte(input logic [7:0] code);
    logic [7:0] mapped;
    if (code == scd_pkg::PREFIX_BYTE) begin
      // A repeated prefix leaves the flag set.
      prefix_armed = 1'b1;
    end else if ((code & RELEASE_MASK) != 8'h00) begin
      // A release clears the prefix and produces no key.
      prefix_armed = 1'b0;
    end else if (prefix_armed) begin
      // Only the four arrow make codes mean anything after the prefix.
      prefix_armed = 1'b0;
      case (code)
        scd_pkg::MAKE_UP:    store_key(scd_pkg::ARROW_UP);
        scd_pkg::MAKE_DOWN:  store_key(scd_pkg::ARROW_DOWN);
        scd_pkg::MAKE_LEFT:  store_key(scd_pkg::ARROW_LEFT);
        scd_pkg::MAKE_RIGHT: store_key(scd_pkg::ARROW_RIGHT);
        default: ;
      endcase
    end else if (int'(code) < MAP_ENTRIES) begin
      mapped = KEYMAP[8*(MAP_ENTRIES-1-int'(code)) +: 8];
      if (mapped != 8'h00) begin
        store_key(mapped);
      end
    end
  endfunction

  // Each accepted request produces exactly one result. A scan byte, or a read while no key is
  // queued, produces a result with valid low and a zero code.
  function automatic void predict_result(input logic mode, input logic [7:0] code);
    key_result_t r;
    r = '{key_valid: 1'b0, key_code: 8'h00};
    if (mode == scd_pkg::MODE_SCAN) begin
      decode_scan_byte(code);
    end else if (queued_keys.size() != 0) begin
      r.key_valid = 1'b1;
      r.key_code  = queued_keys.pop_front();
    end
    pending_results.push_back(r);
  endfunction

  // This task sends one request. The sender sometimes idles first, with push low. A
  // request is accepted at the first rising edge where push is high and full is low. This task
  // leaves push high, so the next request can follow without a gap.
  task automatic send_request(input logic mode, input logic [7:0] code);
    while (!steady_flow && $urandom_range(99) < 14) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push         <= 1'b1;
    in_mode      <= mode;
    in_scan_byte <= code;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_result(mode, code);
    requests_sent++;
  endtask

  task automatic read_key();
    send_request(scd_pkg::MODE_READ, 8'($urandom_range(255)));
  endtask

  task automatic type_byte(input logic [7:0] code);
    send_request(scd_pkg::MODE_SCAN, code);
  endtask

  task automatic report_mismatch(input string what, input key_result_t want);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch (%s): expected valid=%0b code=%02h, got valid=%0b code=%02h",
               what, want.key_valid, want.key_code, out_key_valid, out_key_code);
    end
  endtask

  // The result side samples outputs on the clock edge. A pop seen at this edge retires the head
  // result. The pop for the next cycle is then chosen, idling with a chance of about 14 in a hundred.
  always @(posedge clk) begin
    key_result_t want;
    if (rst_n && pop && !empty) begin
      if (pending_results.size() == 0) begin
        want = '{key_valid: 1'b0, key_code: 8'h00};
        report_mismatch("result with no request pending", want);
      end else begin
        want = pending_results.pop_front();
        if (out_key_valid !== want.key_valid) begin
          report_mismatch("key_valid", want);
        end else if (out_key_code !== want.key_code) begin
          report_mismatch("key_code", want);
        end
      end
    end
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      pop <= steady_flow || ($urandom_range(99) >= 14);
    end
  end

  // This test covers the directed corners. It reads an empty queue, sends the map boundaries,
  // releases, arrows, a repeated prefix, a prefix before a non-arrow code, and a prefix cleared
  // by a release. It then reads everything back and reads the empty queue once more.
  task automatic test_directed_cases();
    read_key();
    type_byte(8'h00);         // unmapped, nothing queued
    type_byte(8'h01);         // escape
    type_byte(8'h39);         // space, last map entry
    type_byte(8'h3A);         // just above the map
    type_byte(8'hFF);         // release
    type_byte(8'h1D);         // zero entry inside the map
    type_byte(scd_pkg::PREFIX_BYTE);
    type_byte(scd_pkg::MAKE_UP);
    type_byte(scd_pkg::PREFIX_BYTE);
    type_byte(scd_pkg::MAKE_DOWN);
    type_byte(scd_pkg::PREFIX_BYTE);
    type_byte(scd_pkg::MAKE_LEFT);
    type_byte(scd_pkg::PREFIX_BYTE);
    type_byte(scd_pkg::PREFIX_BYTE);   // repeated prefix keeps it armed
    type_byte(scd_pkg::MAKE_RIGHT);
    type_byte(scd_pkg::PREFIX_BYTE);
    type_byte(8'h10);         // non-arrow after prefix: dropped
    type_byte(scd_pkg::PREFIX_BYTE);
    type_byte(8'hC8);         // release clears the prefix
    type_byte(scd_pkg::MAKE_UP);       // plain 0x48 is above the map
    repeat (7) read_key();
  endtask

  // This test fills the key FIFO past its capacity so that keys get dropped. It then drains the
  // FIFO with a few extra reads, so the pointers wrap and the empty queue is read again.
  task automatic test_fill_to_capacity();
    int k;
    for (k = 0; k < FIFO_DEPTH + 12; k++) begin
      if (k % 9 == 4) begin
        type_byte(scd_pkg::PREFIX_BYTE);
        type_byte(scd_pkg::MAKE_RIGHT);
      end else begin
        type_byte(8'($urandom_range(8'h01, 8'h39)));
      end
    end
    repeat (FIFO_DEPTH + 4) read_key();
  endtask

  // This task sends random requests. Most are well-formed typing: make codes, release codes and
  // prefixed arrow sequences. The rest is noise, such as prefixes followed by arbitrary bytes
  // and fully random bytes. The read share sets whether the queue tends to fill or to drain.
  task automatic send_random_typing(input int count, input int read_pct);
    int stop_at;
    int pick;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < read_pct) begin
        read_key();
      end else begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          type_byte(8'($urandom_range(8'h00, 8'h39)));
        end else if (pick < 60) begin
          type_byte(8'($urandom_range(127)) | RELEASE_MASK);
        end else if (pick < 78) begin
          type_byte(scd_pkg::PREFIX_BYTE);
          if ($urandom_range(9) == 0) type_byte(scd_pkg::PREFIX_BYTE);
          case ($urandom_range(4))
            0: type_byte(scd_pkg::MAKE_UP);
            1: type_byte(scd_pkg::MAKE_DOWN);
            2: type_byte(scd_pkg::MAKE_LEFT);
            3: type_byte(scd_pkg::MAKE_RIGHT);
            default: type_byte(8'($urandom_range(127)) | RELEASE_MASK);
          endcase
        end else if (pick < 90) begin
          type_byte(scd_pkg::PREFIX_BYTE);
          type_byte(8'($urandom_range(255)));
        end else begin
          type_byte(8'($urandom_range(255)));
        end
      end
    end
  endtask

  // This test runs random typing in four phases. The first is mixed traffic. The second runs
  // with no idling on either side. The third is mostly typing, so the FIFO fills and drops keys.
  // The fourth is mostly reads, so the FIFO drains and empty reads occur.
  task automatic test_random_typing();
    send_random_typing(500, 35);
    steady_flow = 1'b1;
    send_random_typing(300, 40);
    steady_flow = 1'b0;
    send_random_typing(300, 10);
    send_random_typing(300, 60);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_fill_to_capacity();
    test_random_typing();
    push <= 1'b0;

    // Wait for every pending result. Then wait on, so that any stray result the block
    // still emits reaches the checker.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // This is the timeout. It is far longer than the slowest correct run.
  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/scd_pkg.sv
hdl/scd_front.sv
hdl/scd_opq.sv
hdl/scd_back.sv
hdl/scancode_to_key_fifo_top.sv
tb/tb.sv
